FILE: hdl/aarm_pkg.sv
`default_nettype none

package aarm_pkg;

   // Field and datapath widths.
   localparam int IN_W = 16;
   localparam int OUT_W = 16;
   localparam int SQRT_STEPS = 20;
   localparam int ROOT_W = 20;
   localparam int RAD_W = 40;
   localparam int REM_W = 22;
   localparam int DIV_STEPS = 32;
   localparam int DREM_W = 20;
   localparam int ANG_W = 36;
   localparam int UNIT_W = 32;
   localparam int TRIG_W = 33;
   localparam int ENTRY_W = 36;
   localparam int FRAC_Q = 30;
   localparam int ANG_SHIFT = 14;
   localparam int CORDIC_STAGES_DEF = 16;

   // Angle constants in Q6.30 radians.
   localparam logic signed [ANG_W-1:0] FOUR_PI_Q30 = 36'sd13493037704;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
   localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [ANG_W-1:0] GAIN_INV_Q30 = 36'sd652032875;
   localparam logic signed [TRIG_W-1:0] ONE_Q30 = 33'sd1073741824;

   // Square root chain, one result bit per cell.
   typedef struct packed {
      logic valid;
      logic zero;
      logic [2:0][IN_W-1:0] rv;
      logic [RAD_W-1:0] rad;
      logic [REM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   // Rotation-mode CORDIC chain.
   typedef struct packed {
      logic valid;
      logic zero;
      logic neg_cos;
      logic [2:0][IN_W-1:0] rv;
      logic [ROOT_W-1:0] n;
      logic signed [ANG_W-1:0] x;
      logic signed [ANG_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } cordic_type;

   // Three-lane restoring divider chain, one quotient bit per cell.
   typedef struct packed {
      logic valid;
      logic zero;
      logic signed [TRIG_W-1:0] s;
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] t;
      logic [2:0] neg;
      logic [ROOT_W-1:0] n;
      logic [2:0][DREM_W-1:0] rem;
      logic [2:0][UNIT_W-1:0] q;
   } div_type;

   // Arctangent of 2^-step in Q6.30, rounded to nearest.
   function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned step);
      logic signed [ANG_W-1:0] angle;
      case (step)
         0: angle = 36'sd843314857;
         1: angle = 36'sd497837829;
         2: angle = 36'sd263043837;
         3: angle = 36'sd133525159;
         4: angle = 36'sd67021687;
         5: angle = 36'sd33543516;
         6: angle = 36'sd16775851;
         7: angle = 36'sd8388437;
         8: angle = 36'sd4194283;
         9: angle = 36'sd2097149;
         default: begin
            if (step <= FRAC_Q) begin
               angle = ANG_W'(64'd1 << (FRAC_Q - step));
            end else begin
               angle = '0;
            end
         end
      endcase
      return angle;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/aarm_if.sv
`default_nettype none

// Rotation vector channel.
interface aarm_req_if import aarm_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [IN_W-1:0] rot_x;
   logic signed [IN_W-1:0] rot_y;
   logic signed [IN_W-1:0] rot_z;

   modport source(output valid, rot_x, rot_y, rot_z, input ready);
   modport sink(input valid, rot_x, rot_y, rot_z, output ready);
endinterface

// Rotation matrix channel.
interface aarm_rsp_if import aarm_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [OUT_W-1:0] m00;
   logic signed [OUT_W-1:0] m01;
   logic signed [OUT_W-1:0] m02;
   logic signed [OUT_W-1:0] m10;
   logic signed [OUT_W-1:0] m11;
   logic signed [OUT_W-1:0] m12;
   logic signed [OUT_W-1:0] m20;
   logic signed [OUT_W-1:0] m21;
   logic signed [OUT_W-1:0] m22;

   modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
   modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/axis_angle_to_rotation_matrix_core.sv
// Pipeline from an accepted transaction to rsp valid: 20 square-root cells,
// the CORDIC cells and 32 divider cells, plus squaring, angle reduction and
// product stages.
// Throughput: one transaction per cycle while the skid register is empty; it
// holds one result behind a stalled output register and then closes the input.
// Reset clears all valid bits; the datapath holds no other state.
`default_nettype none

module axis_angle_to_rotation_matrix_core import aarm_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input logic clock,
   input logic reset,
   aarm_req_if.sink req_bus,
   aarm_rsp_if.source rsp_bus
);

   localparam int PAIR_A [6] = '{0, 1, 2, 0, 0, 1};
   localparam int PAIR_B [6] = '{0, 1, 2, 1, 2, 2};
   localparam logic signed [ENTRY_W-1:0] ROUND_BIAS = 36'sd32768;
   localparam logic signed [ENTRY_W-1:0] SAT_POS = 36'sd16384;
   localparam logic signed [ENTRY_W-1:0] SAT_NEG = -36'sd16384;
   localparam logic [OUT_W-1:0] OUT_ONE = 16'd16384;
   localparam logic [OUT_W-1:0] OUT_MINUS_ONE = 16'hC000;
   localparam int OUT_SHIFT = 16;

   typedef struct packed {
      logic valid;
      logic zero;
      logic [2:0][IN_W-1:0] rv;
      logic [ROOT_W-1:0] n;
      logic signed [ANG_W-1:0] ang;
   } red_type;

   logic en;

   // Squares.
   logic sq_valid_ff;
   logic [2:0][IN_W-1:0] sq_rv_ff;
   logic [2*IN_W-2:0] sq_ff [3];
   logic signed [2*IN_W-1:0] sq_in [3];

   // Sum of squares and square-root chain.
   sqrt_type sqrt_head_in;
   sqrt_type sqrt_head_ff;
   sqrt_type sqrt_link [SQRT_STEPS+1];

   // Angle reduction.
   red_type red1_in, red1_ff, red2_in, red2_ff, red3_in, red3_ff;
   logic signed [ANG_W-1:0] ang_raw;

   // CORDIC chain.
   cordic_type cordic_head_in;
   cordic_type cordic_head_ff;
   cordic_type cordic_link [CORDIC_STAGES+1];

   // Divider chain.
   div_type div_head_in;
   div_type div_head_ff;
   div_type div_link [DIV_STEPS+1];
   logic signed [IN_W:0] rot_ext [3];
   logic [IN_W:0] rot_mag [3];
   logic signed [TRIG_W-1:0] x_trig;

   // Unit axis and products.
   logic u_valid_ff, u_zero_ff;
   logic signed [UNIT_W-1:0] u_in [3];
   logic signed [UNIT_W-1:0] u_ff [3];
   logic signed [TRIG_W-1:0] u_s_ff, u_c_ff, u_t_ff;

   logic p1_valid_ff, p1_zero_ff;
   logic signed [2*UNIT_W-1:0] prod_uu [6];
   logic signed [TRIG_W+UNIT_W-1:0] prod_su [3];
   logic signed [UNIT_W-1:0] pp_in [6];
   logic signed [UNIT_W-1:0] pp_ff [6];
   logic signed [TRIG_W-1:0] su_in [3];
   logic signed [TRIG_W-1:0] su_ff [3];
   logic signed [TRIG_W-1:0] p1_c_ff, p1_t_ff;

   logic p2_valid_ff, p2_zero_ff;
   logic signed [TRIG_W+UNIT_W-1:0] prod_tp [6];
   logic signed [TRIG_W-1:0] tp_in [6];
   logic signed [TRIG_W-1:0] tp_ff [6];
   logic signed [TRIG_W-1:0] p2_su_ff [3];
   logic signed [TRIG_W-1:0] p2_c_ff;

   logic m_valid_ff, m_zero_ff;
   logic signed [ENTRY_W-1:0] m_in [9];
   logic signed [ENTRY_W-1:0] m_ff [9];

   // Output register and skid register.
   logic signed [ENTRY_W-1:0] rnd [9];
   logic [8:0][OUT_W-1:0] res;
   logic [8:0][OUT_W-1:0] out_ff;
   logic [8:0][OUT_W-1:0] skid_ff;
   logic out_valid_ff;
   logic skid_valid_ff;

   // The whole pipeline moves while the skid register is empty.
   assign en = !skid_valid_ff;
   assign req_bus.ready = en;

   // Stage 1: square each component.
   always_comb begin
      sq_in[0] = req_bus.rot_x * req_bus.rot_x;
      sq_in[1] = req_bus.rot_y * req_bus.rot_y;
      sq_in[2] = req_bus.rot_z * req_bus.rot_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff <= req_bus.valid;
      end
      if (en) begin
         sq_rv_ff <= {req_bus.rot_z, req_bus.rot_y, req_bus.rot_x};
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= sq_in[k][2*IN_W-2:0];
         end
      end
   end

   // Stage 2: sum of squares, scaled by 2^8 for the root.
   always_comb begin
      sqrt_head_in.valid = sq_valid_ff;
      sqrt_head_in.rv = sq_rv_ff;
      sqrt_head_in.rad = {RAD_W'({1'b0, sq_ff[0]} + {1'b0, sq_ff[1]} + {1'b0, sq_ff[2]})}
                         << 8;
      sqrt_head_in.zero = (sqrt_head_in.rad == '0);
      sqrt_head_in.rem = '0;
      sqrt_head_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqrt_head_ff.valid <= 1'b0;
      end else if (en) begin
         sqrt_head_ff <= sqrt_head_in;
      end
   end

   assign sqrt_link[0] = sqrt_head_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      aarm_sqrt_cell #(.STEP(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .from_prev (sqrt_link[g]),
         .to_next   (sqrt_link[g+1])
      );
   end

   // Angle reduction: two steps modulo 2*pi, then wrap into (-pi, pi].
   always_comb begin
      ang_raw = ANG_W'({sqrt_link[SQRT_STEPS].root, {ANG_SHIFT{1'b0}}});
      red1_in.valid = sqrt_link[SQRT_STEPS].valid;
      red1_in.zero = sqrt_link[SQRT_STEPS].zero;
      red1_in.rv = sqrt_link[SQRT_STEPS].rv;
      red1_in.n = sqrt_link[SQRT_STEPS].root;
      red1_in.ang = (ang_raw >= FOUR_PI_Q30) ? ang_raw - FOUR_PI_Q30 : ang_raw;

      red2_in = red1_ff;
      red2_in.ang = (red1_ff.ang >= TWO_PI_Q30) ? red1_ff.ang - TWO_PI_Q30 : red1_ff.ang;

      red3_in = red2_ff;
      red3_in.ang = (red2_ff.ang > PI_Q30) ? red2_ff.ang - TWO_PI_Q30 : red2_ff.ang;
   end

   // Fold into [-pi/2, pi/2] and seed the CORDIC.
   always_comb begin
      cordic_head_in.valid = red3_ff.valid;
      cordic_head_in.zero = red3_ff.zero;
      cordic_head_in.rv = red3_ff.rv;
      cordic_head_in.n = red3_ff.n;
      cordic_head_in.x = GAIN_INV_Q30;
      cordic_head_in.y = '0;
      if (red3_ff.ang > HALF_PI_Q30) begin
         cordic_head_in.z = PI_Q30 - red3_ff.ang;
         cordic_head_in.neg_cos = 1'b1;
      end else if (red3_ff.ang < -HALF_PI_Q30) begin
         cordic_head_in.z = -PI_Q30 - red3_ff.ang;
         cordic_head_in.neg_cos = 1'b1;
      end else begin
         cordic_head_in.z = red3_ff.ang;
         cordic_head_in.neg_cos = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red1_ff.valid <= 1'b0;
         red2_ff.valid <= 1'b0;
         red3_ff.valid <= 1'b0;
         cordic_head_ff.valid <= 1'b0;
      end else if (en) begin
         red1_ff <= red1_in;
         red2_ff <= red2_in;
         red3_ff <= red3_in;
         cordic_head_ff <= cordic_head_in;
      end
   end

   assign cordic_link[0] = cordic_head_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      aarm_cordic_cell #(.STEP(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .from_prev (cordic_link[g]),
         .to_next   (cordic_link[g+1])
      );
   end

   // Sine, cosine, 1 - cos, and the divider seeds |v| * 4.
   always_comb begin
      x_trig = TRIG_W'(cordic_link[CORDIC_STAGES].x);
      div_head_in.valid = cordic_link[CORDIC_STAGES].valid;
      div_head_in.zero = cordic_link[CORDIC_STAGES].zero;
      div_head_in.n = cordic_link[CORDIC_STAGES].n;
      div_head_in.s = TRIG_W'(cordic_link[CORDIC_STAGES].y);
      div_head_in.c = cordic_link[CORDIC_STAGES].neg_cos ? -x_trig : x_trig;
      div_head_in.t = cordic_link[CORDIC_STAGES].neg_cos ? ONE_Q30 + x_trig
                                                         : ONE_Q30 - x_trig;
      div_head_in.q = '0;
      for (int k = 0; k < 3; k++) begin
         rot_ext[k] = $signed({cordic_link[CORDIC_STAGES].rv[k][IN_W-1],
                               cordic_link[CORDIC_STAGES].rv[k]});
         rot_mag[k] = rot_ext[k][IN_W] ? (IN_W+1)'(-rot_ext[k]) : (IN_W+1)'(rot_ext[k]);
         div_head_in.neg[k] = rot_ext[k][IN_W];
         div_head_in.rem[k] = DREM_W'({rot_mag[k], 2'b00});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_head_ff.valid <= 1'b0;
      end else if (en) begin
         div_head_ff <= div_head_in;
      end
   end

   assign div_link[0] = div_head_ff;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      aarm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .from_prev (div_link[g]),
         .to_next   (div_link[g+1])
      );
   end

   // Unit axis: restore the sign of each quotient.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_in[k] = div_link[DIV_STEPS].neg[k] ? UNIT_W'(-div_link[DIV_STEPS].q[k])
                                              : UNIT_W'(div_link[DIV_STEPS].q[k]);
      end
   end

   // First products: axis pairs and sine times axis.
   always_comb begin
      for (int p = 0; p < 6; p++) begin
         prod_uu[p] = u_ff[PAIR_A[p]] * u_ff[PAIR_B[p]];
         pp_in[p] = UNIT_W'(prod_uu[p] >>> FRAC_Q);
      end
      for (int k = 0; k < 3; k++) begin
         prod_su[k] = u_s_ff * u_ff[k];
         su_in[k] = TRIG_W'(prod_su[k] >>> FRAC_Q);
      end
   end

   // Second products: scale the pair terms by 1 - cos.
   always_comb begin
      for (int p = 0; p < 6; p++) begin
         prod_tp[p] = p1_t_ff * pp_ff[p];
         tp_in[p] = TRIG_W'(prod_tp[p] >>> FRAC_Q);
      end
   end

   // Matrix entries in row-major order.
   always_comb begin
      m_in[0] = ENTRY_W'(tp_ff[0]) + ENTRY_W'(p2_c_ff);
      m_in[4] = ENTRY_W'(tp_ff[1]) + ENTRY_W'(p2_c_ff);
      m_in[8] = ENTRY_W'(tp_ff[2]) + ENTRY_W'(p2_c_ff);
      m_in[1] = ENTRY_W'(tp_ff[3]) - ENTRY_W'(p2_su_ff[2]);
      m_in[3] = ENTRY_W'(tp_ff[3]) + ENTRY_W'(p2_su_ff[2]);
      m_in[2] = ENTRY_W'(tp_ff[4]) + ENTRY_W'(p2_su_ff[1]);
      m_in[6] = ENTRY_W'(tp_ff[4]) - ENTRY_W'(p2_su_ff[1]);
      m_in[5] = ENTRY_W'(tp_ff[5]) - ENTRY_W'(p2_su_ff[0]);
      m_in[7] = ENTRY_W'(tp_ff[5]) + ENTRY_W'(p2_su_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
      end else if (en) begin
         u_valid_ff <= div_link[DIV_STEPS].valid;
         p1_valid_ff <= u_valid_ff;
         p2_valid_ff <= p1_valid_ff;
         m_valid_ff <= p2_valid_ff;
      end
      if (en) begin
         u_zero_ff <= div_link[DIV_STEPS].zero;
         u_s_ff <= div_link[DIV_STEPS].s;
         u_c_ff <= div_link[DIV_STEPS].c;
         u_t_ff <= div_link[DIV_STEPS].t;
         u_ff <= u_in;
         p1_zero_ff <= u_zero_ff;
         p1_c_ff <= u_c_ff;
         p1_t_ff <= u_t_ff;
         pp_ff <= pp_in;
         su_ff <= su_in;
         p2_zero_ff <= p1_zero_ff;
         p2_c_ff <= p1_c_ff;
         p2_su_ff <= su_ff;
         tp_ff <= tp_in;
         m_zero_ff <= p2_zero_ff;
         m_ff <= m_in;
      end
   end

   // Round to Q2.14, saturate, and substitute the identity for a zero vector.
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         rnd[k] = (m_ff[k] + ROUND_BIAS) >>> OUT_SHIFT;
         if (m_zero_ff) begin
            res[k] = (k == 0 || k == 4 || k == 8) ? OUT_ONE : '0;
         end else if (rnd[k] > SAT_POS) begin
            res[k] = OUT_ONE;
         end else if (rnd[k] < SAT_NEG) begin
            res[k] = OUT_MINUS_ONE;
         end else begin
            res[k] = OUT_W'(rnd[k]);
         end
      end
   end

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         if (m_valid_ff && out_valid_ff && !rsp_bus.ready) begin
            skid_ff <= res;
            skid_valid_ff <= 1'b1;
         end else if (m_valid_ff) begin
            out_ff <= res;
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end else if (rsp_bus.ready) begin
         out_ff <= skid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.m00 = out_ff[0];
   assign rsp_bus.m01 = out_ff[1];
   assign rsp_bus.m02 = out_ff[2];
   assign rsp_bus.m10 = out_ff[3];
   assign rsp_bus.m11 = out_ff[4];
   assign rsp_bus.m12 = out_ff[5];
   assign rsp_bus.m20 = out_ff[6];
   assign rsp_bus.m21 = out_ff[7];
   assign rsp_bus.m22 = out_ff[8];

`ifndef ASSERT_OFF
   // The skid register only fills behind a held output transaction.
   skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register is empty");

   // A finished result meeting a stalled output must be caught by the skid register.
   spill_caught: assert property (@(posedge clock) disable iff (reset)
      (en && m_valid_ff && out_valid_ff && !rsp_bus.ready) |=> skid_valid_ff)
      else $error("result lost at a stalled output");

   // Draining the skid register leaves its transaction in the output register.
   drain_keeps_out: assert property (@(posedge clock) disable iff (reset)
      $fell(skid_valid_ff) |-> out_valid_ff)
      else $error("skid transaction dropped while draining");
`endif

endmodule

`default_nettype wire

FILE: hdl/aarm_sqrt_cell.sv
`default_nettype none

module aarm_sqrt_cell import aarm_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  sqrt_type from_prev,
   output sqrt_type to_next
);

   localparam int BIT_LO = 2 * (SQRT_STEPS - 1 - STEP);

   logic [REM_W+1:0] trial_rem;
   logic [REM_W+1:0] trial_sub;
   logic fits;
   sqrt_type stage_in;
   sqrt_type stage_ff;

   // Bring down the next bit pair and try to subtract 4*root + 1.
   always_comb begin
      trial_rem = {from_prev.rem, from_prev.rad[BIT_LO+1:BIT_LO]};
      trial_sub = {{(REM_W - ROOT_W){1'b0}}, from_prev.root, 2'b01};
      fits = (trial_rem >= trial_sub);
      stage_in = from_prev;
      stage_in.rem = fits ? REM_W'(trial_rem - trial_sub) : REM_W'(trial_rem);
      stage_in.root = {from_prev.root[ROOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign to_next = stage_ff;

endmodule

`default_nettype wire

FILE: hdl/aarm_cordic_cell.sv
`default_nettype none

module aarm_cordic_cell import aarm_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  cordic_type from_prev,
   output cordic_type to_next
);

   localparam logic signed [ANG_W-1:0] ATAN_STEP = atan_q30(STEP);

   logic signed [ANG_W-1:0] dx;
   logic signed [ANG_W-1:0] dy;
   cordic_type stage_in;
   cordic_type stage_ff;

   // One micro-rotation, direction chosen by the sign of the residual angle.
   always_comb begin
      dx = from_prev.y >>> STEP;
      dy = from_prev.x >>> STEP;
      stage_in = from_prev;
      if (from_prev.z >= 0) begin
         stage_in.x = from_prev.x - dx;
         stage_in.y = from_prev.y + dy;
         stage_in.z = from_prev.z - ATAN_STEP;
      end else begin
         stage_in.x = from_prev.x + dx;
         stage_in.y = from_prev.y - dy;
         stage_in.z = from_prev.z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign to_next = stage_ff;

endmodule

`default_nettype wire

FILE: hdl/aarm_div_cell.sv
`default_nettype none

module aarm_div_cell import aarm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  div_type from_prev,
   output div_type to_next
);

   logic [DREM_W:0] shifted [3];
   logic [2:0] fits;
   div_type stage_in;
   div_type stage_ff;

   // One restoring step in each of the three lanes against the norm.
   always_comb begin
      stage_in = from_prev;
      for (int k = 0; k < 3; k++) begin
         shifted[k] = {from_prev.rem[k], 1'b0};
         fits[k] = (shifted[k] >= {1'b0, from_prev.n});
         stage_in.rem[k] = fits[k] ? DREM_W'(shifted[k] - {1'b0, from_prev.n})
                                   : DREM_W'(shifted[k]);
         stage_in.q[k] = {from_prev.q[k][UNIT_W-2:0], fits[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign to_next = stage_ff;

endmodule

`default_nettype wire

FILE: sim/axis_angle_to_rotation_matrix_core_tb.sv
`timescale 1ns / 1ps

module axis_angle_to_rotation_matrix_core_tb;
   import aarm_pkg::*;

   typedef logic [8:0][OUT_W-1:0] matrix_type;
   typedef logic [2:0][IN_W-1:0] rotvec_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 200;
   localparam int STAGES = CORDIC_STAGES_DEF;

   logic clock;
   logic reset;

   aarm_req_if req_bus ();
   aarm_rsp_if rsp_bus ();

   axis_angle_to_rotation_matrix_core dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   rotvec_type vectors_to_send[$];
   matrix_type matrices_due[$];
   int sender_idle_pct;
   int receiver_stall_pct;
   int holdoff_request;
   int holdoff_left;
   int error_count;
   int cycle_count;
   logic req_taken;

   // Integer square root, one result bit per step.
   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned rem, root, bitv;
      rem = v;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return (a * b) >>> FRAC_Q;
   endfunction

   function automatic logic [OUT_W-1:0] round_sat_q14(input longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[OUT_W-1:0];
   endfunction

   // Rodrigues formula with CORDIC sine and cosine, at the block's precision.
   function automatic matrix_type rotation_matrix(input rotvec_type rv);
      longint v[3];
      longint u[3];
      longint m[9];
      longint unsigned sumsq, n;
      longint ang, x, y, z, dx, dy, s, c, t, txy, txz, tyz, sx, sy, sz;
      bit neg_cos;
      matrix_type res;
      for (int k = 0; k < 3; k++) v[k] = longint'($signed(rv[k]));
      sumsq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      if (sumsq == 0) begin
         for (int k = 0; k < 9; k++) res[k] = (k % 4 == 0) ? 16'd16384 : 16'd0;
         return res;
      end
      n = isqrt(sumsq << 8);
      // Reduce the angle into (-pi, pi], then fold into [-pi/2, pi/2].
      ang = longint'((n << ANG_SHIFT) % longint'(TWO_PI_Q30));
      if (ang > longint'(PI_Q30)) ang = ang - longint'(TWO_PI_Q30);
      neg_cos = 0;
      if (ang > longint'(HALF_PI_Q30)) begin
         ang = longint'(PI_Q30) - ang;
         neg_cos = 1;
      end else if (ang < -longint'(HALF_PI_Q30)) begin
         ang = -longint'(PI_Q30) - ang;
         neg_cos = 1;
      end
      x = longint'(GAIN_INV_Q30);
      y = 0;
      z = ang;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(atan_q30(i));
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(atan_q30(i));
         end
      end
      s = y;
      c = neg_cos ? -x : x;
      t = longint'(ONE_Q30) - c;
      for (int k = 0; k < 3; k++) u[k] = (v[k] * (64'sd1 <<< 34)) / longint'(n);
      m[0] = qmul(t, qmul(u[0], u[0])) + c;
      m[4] = qmul(t, qmul(u[1], u[1])) + c;
      m[8] = qmul(t, qmul(u[2], u[2])) + c;
      txy = qmul(t, qmul(u[0], u[1]));
      txz = qmul(t, qmul(u[0], u[2]));
      tyz = qmul(t, qmul(u[1], u[2]));
      sx = qmul(s, u[0]);
      sy = qmul(s, u[1]);
      sz = qmul(s, u[2]);
      m[1] = txy - sz;
      m[3] = txy + sz;
      m[2] = txz + sy;
      m[6] = txz - sy;
      m[5] = tyz - sx;
      m[7] = tyz + sx;
      for (int k = 0; k < 9; k++) res[k] = round_sat_q14(m[k]);
      return res;
   endfunction

   // Clock generation.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // All inputs start at known values.
   initial begin
      reset = 1;
      req_bus.valid = 0;
      req_bus.rot_x = '0;
      req_bus.rot_y = '0;
      req_bus.rot_z = '0;
      rsp_bus.ready = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      holdoff_request = 0;
      error_count = 0;
      cycle_count = 0;
   end

   // Sample request acceptance at the rising edge and predict the matrix.
   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         matrices_due.insert(matrices_due.size(),
                             rotation_matrix({req_bus.rot_z, req_bus.rot_y, req_bus.rot_x}));
      end
   end

   // Driver: a valid transaction is held until it is accepted.
   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || req_taken)) begin
         if (vectors_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_bus.valid <= 1'b1;
            req_bus.rot_x <= vectors_to_send[0][0];
            req_bus.rot_y <= vectors_to_send[0][1];
            req_bus.rot_z <= vectors_to_send[0][2];
            void'(vectors_to_send.pop_front());
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted in its own process.
   always @(posedge clock) begin
      if (holdoff_request > 0) begin
         holdoff_left <= holdoff_request;
         holdoff_request <= 0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end else begin
         holdoff_left <= 0;
      end
   end

   // Receiver ready, with random stalls.
   always @(negedge clock) begin
      if (reset || holdoff_left > 0) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Monitor: compare each result transaction with the oldest prediction.
   always @(posedge clock) begin
      matrix_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.m22, rsp_bus.m21, rsp_bus.m20, rsp_bus.m12, rsp_bus.m11,
                rsp_bus.m10, rsp_bus.m02, rsp_bus.m01, rsp_bus.m00};
         if (matrices_due.size() == 0) begin
            $display("%0t: unexpected result transaction %h", $time, got);
            error_count = error_count + 1;
         end else begin
            want = matrices_due.pop_front();
            for (int k = 0; k < 9; k++) begin
               if (got[k] !== want[k]) begin
                  $display("%0t: m%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
                           $signed(want[k]), $signed(got[k]));
                  error_count = error_count + 1;
               end
            end
         end
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL axis_angle_to_rotation_matrix_core");
         $finish;
      end
   end

   task automatic add_vector(input int x, input int y, input int z);
      rotvec_type rv;
      rv[0] = x[IN_W-1:0];
      rv[1] = y[IN_W-1:0];
      rv[2] = z[IN_W-1:0];
      vectors_to_send.insert(vectors_to_send.size(), rv);
   endtask

   task automatic add_random(input int count);
      int sel, lim;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(3);
         // Half full-range components, a quarter smaller components, a quarter with random components zeroed.
         if (sel == 0) begin
            lim = $urandom_range(6000);
            add_vector($urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                       $urandom_range(2 * lim) - lim);
         end else if (sel == 1) begin
            add_vector($urandom_range(1) ? $urandom : 0, $urandom_range(1) ? $urandom : 0,
                       $urandom_range(1) ? $urandom : 0);
         end else begin
            add_vector($urandom, $urandom, $urandom);
         end
      end
   endtask

   task automatic drain();
      while (vectors_to_send.size() > 0 || req_bus.valid || matrices_due.size() > 0) begin
         @(posedge clock);
      end
   endtask

   // Stimulus sequence.
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: zero vector, extremes, tiny and near-pi angles, single axes.
      add_vector(0, 0, 0);
      add_vector(32767, 32767, 32767);
      add_vector(-32768, -32768, -32768);
      add_vector(32767, 0, 0);
      add_vector(0, -32768, 0);
      add_vector(0, 0, 32767);
      add_vector(1, 0, 0);
      add_vector(0, -1, 0);
      add_vector(0, 0, 1);
      add_vector(1, 1, 1);
      add_vector(-1, -1, -1);
      add_vector(12868, 0, 0);
      add_vector(0, 12868, 0);
      add_vector(0, 0, -12868);
      add_vector(6434, 0, 0);
      add_vector(7430, 7430, 7430);
      add_vector(25736, 0, 0);
      add_vector(-32768, 32767, 0);
      add_vector(32767, -32768, 1);
      add_vector(4096, -4096, 4096);
      drain();

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      add_random(400);
      drain();

      sender_idle_pct = 59;
      receiver_stall_pct = 0;
      add_random(400);
      drain();

      sender_idle_pct = 0;
      receiver_stall_pct = 59;
      add_random(400);
      drain();

      sender_idle_pct = 19;
      receiver_stall_pct = 19;
      add_random(300);
      drain();

      // Receiver holds off while the sender keeps offering, so the pipeline fills.
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      add_random(200);
      holdoff_request = 400;
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS axis_angle_to_rotation_matrix_core");
      end else begin
         $display("FAIL axis_angle_to_rotation_matrix_core");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/aarm_pkg.sv
hdl/aarm_if.sv
hdl/aarm_sqrt_cell.sv
hdl/aarm_cordic_cell.sv
hdl/aarm_div_cell.sv
hdl/axis_angle_to_rotation_matrix_core.sv
sim/axis_angle_to_rotation_matrix_core_tb.sv
